// ===== src/bmft_pkg.sv =====
`timescale 1ns / 1ps
// shared constants for the budget match fitness tracker
package bmft_pkg;

  localparam int MAX_ASSETS      = 8;
  localparam int MAX_FIELD_BITS  = 8;
  localparam int CHROMOSOME_BITS = 64;

  localparam int GENE_W   = 64;
  localparam int COST_W   = 27;
  localparam int FIT_W    = 54;
  localparam int PRICE_W  = 16;
  localparam int LEN_W    = 4;
  localparam int COUNT_W  = 4;
  localparam int QTY_W    = MAX_FIELD_BITS;
  localparam int MUL_W    = 27;
  localparam int PROD_W   = 2 * MUL_W;
  localparam int ASSET_W  = (MAX_ASSETS > 1) ? $clog2(MAX_ASSETS) : 1;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 64;

  localparam logic [GENE_W-1:0] GENE_MASK = {GENE_W{1'b1}} >> (GENE_W - CHROMOSOME_BITS);

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_ASSET_COUNT   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FIELD_LENGTHS = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_PRICES_LOW    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_PRICES_HIGH   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_BUDGET        = 3'd4;

endpackage

// ===== src/bmft_if.sv =====
`timescale 1ns / 1ps
// valid/ready channel interfaces for chromosome words and result words
interface bmft_in_if;
  logic                       valid;
  logic                       ready;
  logic [bmft_pkg::GENE_W-1:0] chromosome;

  modport source (output valid, output chromosome, input ready);
  modport sink   (input valid, input chromosome, output ready);
endinterface

interface bmft_out_if;
  logic                        valid;
  logic                        ready;
  logic [bmft_pkg::COST_W-1:0] item_cost;
  logic [bmft_pkg::FIT_W-1:0]  fitness;
  logic                        is_new_best;
  logic [bmft_pkg::GENE_W-1:0] best_chromosome;
  logic [bmft_pkg::FIT_W-1:0]  best_fitness;
  logic [bmft_pkg::COST_W-1:0] best_cost;

  modport source (output valid, output item_cost, output fitness, output is_new_best,
                  output best_chromosome, output best_fitness, output best_cost,
                  input ready);
  modport sink   (input valid, input item_cost, input fitness, input is_new_best,
                  input best_chromosome, input best_fitness, input best_cost,
                  output ready);
endinterface

// ===== src/bmft_mul.sv =====
`timescale 1ns / 1ps
// shared multiplier with registered product
module bmft_mul (
  input  logic                        clk,
  input  logic                        en,
  input  logic [bmft_pkg::MUL_W-1:0]  op_a,
  input  logic [bmft_pkg::MUL_W-1:0]  op_b,
  output logic [bmft_pkg::PROD_W-1:0] prod
);
  import bmft_pkg::*;

  logic [PROD_W-1:0] prod_r;

  // product register, loaded when the sequencer asks
  always_ff @(posedge clk) begin
    if (en) begin
      prod_r <= op_a * op_b;
    end
  end

  assign prod = prod_r;

endmodule

// ===== src/budget_match_fitness_tracker_core.sv =====
`timescale 1ns / 1ps
// budget match fitness tracker top level: sequencer, datapath and best tracking
//
//   channel | dir | handshake           | word
//   in_ch   | in  | valid / ready       | chromosome
//   out_ch  | out | valid / ready       | cost, fitness, new-best flag, best record
//   cfg     | in  | cfg_we, no back-pressure | register index and data
//
// a chromosome passes the accept, an asset step for each asset through the shared multiplier,
// then sum, difference, square and compare; the asset count saturates at eight, and with
// none the asset and sum steps are skipped. only one word is in work at a time.
// rst_n is synchronous; it clears the sequencer, the best record and the output valid flag,
// and loads eight assets with zero lengths, prices and budget; datapath registers keep theirs.
// the result sits in an output register; a new word is taken while it waits,
// and the compare step stalls only if the previous result is still not taken.
module budget_match_fitness_tracker_core (
  input  logic                              clk,
  input  logic                              rst_n,
  bmft_in_if.sink                           in_ch,
  bmft_out_if.source                        out_ch,
  input  logic                              cfg_we,
  input  logic [bmft_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [bmft_pkg::CFG_DATA_W-1:0]   cfg_data
);
  import bmft_pkg::*;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_ASSET = 3'd1;
  localparam logic [2:0] S_SUM   = 3'd2;
  localparam logic [2:0] S_DIFF  = 3'd3;
  localparam logic [2:0] S_SQ    = 3'd4;
  localparam logic [2:0] S_CMP   = 3'd5;

  // configuration registers
  logic [COUNT_W-1:0]              asset_count_r;
  logic [MAX_ASSETS*LEN_W-1:0]     field_lengths_r;
  logic [MAX_ASSETS*PRICE_W-1:0]   prices_r;
  logic [COST_W-1:0]               budget_r;

  // sequencer and datapath
  logic [2:0]         state_r, state_nxt;
  logic [ASSET_W-1:0] asset_r, asset_nxt;
  logic [GENE_W-1:0]  genes_r;
  logic [GENE_W-1:0]  shift_r, shift_nxt;
  logic [COST_W-1:0]  acc_r, acc_nxt;
  logic [COST_W-1:0]  diff_r;

  // best record
  logic               best_valid_r;
  logic [GENE_W-1:0]  best_genes_r;
  logic [FIT_W-1:0]   best_score_r;
  logic [COST_W-1:0]  best_total_r;

  // output register
  logic               out_vld_r;
  logic [COST_W-1:0]  out_cost_r;
  logic [FIT_W-1:0]   out_fit_r;
  logic               out_new_r;

  logic               in_acc;
  logic               out_free;
  logic [COUNT_W-1:0] n_eff;
  logic [LEN_W-1:0]   len_raw, len_eff;
  logic [QTY_W-1:0]   qty;
  logic [PRICE_W-1:0] price;
  logic               last_asset;
  logic               mul_en;
  logic [MUL_W-1:0]   mul_a, mul_b;
  logic [PROD_W-1:0]  prod;
  logic [FIT_W-1:0]   fit;
  logic [GENE_W-1:0]  g_rev, b_rev;
  logic               take;

  assign in_acc   = in_ch.valid && in_ch.ready;
  assign out_free = !out_vld_r || out_ch.ready;
  assign in_ch.ready = (state_r == S_IDLE);

  // saturated asset count and field length
  assign n_eff   = (asset_count_r > COUNT_W'(MAX_ASSETS)) ? COUNT_W'(MAX_ASSETS)
                                                          : asset_count_r;
  assign len_raw = field_lengths_r[asset_r*LEN_W +: LEN_W];
  assign len_eff = (len_raw > LEN_W'(MAX_FIELD_BITS)) ? LEN_W'(MAX_FIELD_BITS) : len_raw;
  assign price   = prices_r[asset_r*PRICE_W +: PRICE_W];
  assign last_asset = ({1'b0, asset_r} + (COUNT_W)'(1)) >= n_eff;

  // quantity: first gene of the field is the msb
  always_comb begin
    qty = '0;
    for (int b = 0; b < QTY_W; b++) begin
      if (LEN_W'(b) < len_eff) begin
        qty[b] = shift_r[len_eff - LEN_W'(b) - LEN_W'(1)];
      end
    end
  end

  // multiplier operand select: asset product or square
  always_comb begin
    mul_en = 1'b0;
    mul_a  = '0;
    mul_b  = '0;
    case (state_r)
      S_ASSET: begin
        mul_en = 1'b1;
        mul_a  = MUL_W'(qty);
        mul_b  = MUL_W'(price);
      end
      S_SQ: begin
        mul_en = 1'b1;
        mul_a  = MUL_W'(diff_r);
        mul_b  = MUL_W'(diff_r);
      end
      default: begin
        mul_en = 1'b0;
      end
    endcase
  end

  bmft_mul u_mul (
    .clk  (clk),
    .en   (mul_en),
    .op_a (mul_a),
    .op_b (mul_b),
    .prod (prod)
  );

  assign fit = prod[FIT_W-1:0];

  // chromosome order: first differing bit from bit 0, so compare bit-reversed
  always_comb begin
    for (int i = 0; i < GENE_W; i++) begin
      g_rev[i] = genes_r[GENE_W-1-i];
      b_rev[i] = best_genes_r[GENE_W-1-i];
    end
  end

  always_comb begin
    if (!best_valid_r) begin
      take = 1'b1;
    end else if (fit != best_score_r) begin
      take = fit < best_score_r;
    end else if (acc_r != best_total_r) begin
      take = acc_r < best_total_r;
    end else begin
      take = g_rev < b_rev;
    end
  end

  // sequencer next state
  always_comb begin
    state_nxt = state_r;
    asset_nxt = asset_r;
    shift_nxt = shift_r;
    acc_nxt   = acc_r;
    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          asset_nxt = '0;
          shift_nxt = in_ch.chromosome & GENE_MASK;
          acc_nxt   = '0;
          state_nxt = (n_eff == '0) ? S_DIFF : S_ASSET;
        end
      end
      S_ASSET: begin
        if (asset_r != '0) begin
          acc_nxt = acc_r + prod[COST_W-1:0];
        end
        shift_nxt = shift_r >> len_eff;
        asset_nxt = asset_r + ASSET_W'(1);
        if (last_asset) begin
          state_nxt = S_SUM;
        end
      end
      S_SUM: begin
        acc_nxt   = acc_r + prod[COST_W-1:0];
        state_nxt = S_DIFF;
      end
      S_DIFF: begin
        state_nxt = S_SQ;
      end
      S_SQ: begin
        state_nxt = S_CMP;
      end
      S_CMP: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      asset_r      <= '0;
      best_valid_r <= 1'b0;
      best_genes_r <= '0;
      best_score_r <= '0;
      best_total_r <= '0;
      out_vld_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      asset_r <= asset_nxt;
      if (state_r == S_CMP && out_free) begin
        out_vld_r <= 1'b1;
        if (take) begin
          best_valid_r <= 1'b1;
          best_genes_r <= genes_r;
          best_score_r <= fit;
          best_total_r <= acc_r;
        end
      end else if (out_ch.ready) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    shift_r <= shift_nxt;
    acc_r   <= acc_nxt;
    if (in_acc) begin
      genes_r <= in_ch.chromosome & GENE_MASK;
    end
    if (state_r == S_DIFF) begin
      diff_r <= (acc_r >= budget_r) ? (acc_r - budget_r) : (budget_r - acc_r);
    end
    if (state_r == S_CMP && out_free) begin
      out_cost_r <= acc_r;
      out_fit_r  <= fit;
      out_new_r  <= take;
    end
  end

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      asset_count_r   <= COUNT_W'(MAX_ASSETS);
      field_lengths_r <= '0;
      prices_r        <= '0;
      budget_r        <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_ASSET_COUNT:   asset_count_r   <= cfg_data[COUNT_W-1:0];
        CFG_FIELD_LENGTHS: field_lengths_r <= cfg_data[MAX_ASSETS*LEN_W-1:0];
        CFG_PRICES_LOW:    prices_r[4*PRICE_W-1:0] <= cfg_data[4*PRICE_W-1:0];
        CFG_PRICES_HIGH:   prices_r[8*PRICE_W-1:4*PRICE_W] <= cfg_data[4*PRICE_W-1:0];
        CFG_BUDGET:        budget_r        <= cfg_data[COST_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // result word
  assign out_ch.valid           = out_vld_r;
  assign out_ch.item_cost       = out_cost_r;
  assign out_ch.fitness         = out_fit_r;
  assign out_ch.is_new_best     = out_new_r;
  assign out_ch.best_chromosome = best_genes_r;
  assign out_ch.best_fitness    = best_score_r;
  assign out_ch.best_cost       = best_total_r;

`ifndef SYNTHESIS
  // one word in flight: no accept right after an accept
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> !in_ch.ready)
    else $error("word accepted while previous one still in work");

  // a new best must carry this word's cost and fitness
  a_new_best_match: assert property (@(posedge clk) disable iff (!rst_n)
    (out_vld_r && out_new_r) |->
      (best_score_r == out_fit_r && best_total_r == out_cost_r))
    else $error("best record does not match new best word");

  // a kept best is never worse by fitness
  a_kept_best_order: assert property (@(posedge clk) disable iff (!rst_n)
    (out_vld_r && !out_new_r) |-> (best_score_r <= out_fit_r))
    else $error("kept best has larger fitness than rejected word");
`endif

endmodule
